// ----- rtl/dwrs_pkg.sv -----
// Shared types, constants and ring index helper for the deque with reverse and sort.
package dwrs_pkg;

	localparam int DEPTH  = 16;
	localparam int DATA_W = 32;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);

	localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [2:0] OP_POP_FRONT  = 3'd2;
	localparam logic [2:0] OP_POP_BACK   = 3'd3;
	localparam logic [2:0] OP_REVERSE    = 3'd4;
	localparam logic [2:0] OP_SORT       = 3'd5;
	localparam logic [2:0] OP_DUMP       = 3'd6;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [2:0]               op;
		logic signed [DATA_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] front_value;
		logic signed [DATA_W-1:0] back_value;
		logic [CNT_W-1:0]         count;
		logic                     is_empty;
		logic [1:0]               status;
		logic signed [DATA_W-1:0] elem_value;
		logic                     elem_valid;
		logic                     last;
	} rsp_t;

	// Ring position of the element at offset x from the head.
	function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] head,
		input logic [IDX_W-1:0] x);
		logic [IDX_W:0] s;
		s = {1'b0, head} + {1'b0, x};
		if (s >= (IDX_W+1)'(DEPTH)) begin
			s = s - (IDX_W+1)'(DEPTH);
		end
		return s[IDX_W-1:0];
	endfunction

endpackage

// ----- rtl/deque_with_reverse_and_sort.sv -----
// Top level of the bounded deque with reverse, sort and dump commands.
//
// One command transaction enters on cmd (op, value) under cmd_valid/cmd_ready.
// Results leave on rsp under rsp_valid/rsp_ready from an output register.
// Every command except a dump of a non-empty deque yields one summary
// result; such a dump yields one result per stored element from front to
// back, with last set on the final one.
// The block takes one command at a time; cmd_ready is high only when idle.
// Push and pop fetch front and back in S_FETCH and offer the result from
// S_SUM; cmd_ready returns at the edge that registers the result.
// Reverse and sort of more than one element first step through S_READ,
// S_XCHG and, where a pair is exchanged, S_SWAP for each pair.
// Dump reads each element in S_DREAD and offers it from S_DEMIT.
// These steps follow from the single write port and the registered read
// ports of the ring store, which the compare and exchange unit shares.
// Reset empties the deque; store contents are not cleared.
// While the receiver stalls, the held result stays unchanged and the
// sequencer waits with its next result.
module deque_with_reverse_and_sort (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  dwrs_pkg::cmd_t cmd,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output dwrs_pkg::rsp_t rsp
);

	logic           emit;
	logic           take;
	dwrs_pkg::rsp_t res;
	logic           rsp_valid_q;
	dwrs_pkg::rsp_t rsp_q;

	dwrs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd),
		.emit     (emit),
		.take     (take),
		.res      (res)
	);

	assign take = emit && (!rsp_valid_q || rsp_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (take) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- rtl/dwrs_ram.sv -----
// Generic single write port, dual registered read port RAM.
module dwrs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// ----- rtl/dwrs_ctrl.sv -----
// Command sequencer with the shared compare and exchange unit over the ring store.
module dwrs_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  dwrs_pkg::cmd_t cmd,
	output logic          emit,
	input  logic          take,
	output dwrs_pkg::rsp_t res
);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_FETCH = 8'b0000_0010,
		S_SUM   = 8'b0000_0100,
		S_READ  = 8'b0000_1000,
		S_XCHG  = 8'b0001_0000,
		S_SWAP  = 8'b0010_0000,
		S_DREAD = 8'b0100_0000,
		S_DEMIT = 8'b1000_0000
	} state_t;

	state_t                           state_q;
	logic [dwrs_pkg::IDX_W-1:0]       head_q;
	logic [dwrs_pkg::CNT_W-1:0]       count_q;
	logic [2:0]                       op_q;
	logic [1:0]                       status_q;
	logic [dwrs_pkg::CNT_W:0]         i_q;
	logic [dwrs_pkg::CNT_W:0]         j_q;
	logic [dwrs_pkg::DATA_W-1:0]      t_q;
	logic [dwrs_pkg::DATA_W-1:0]      front_q;
	logic [dwrs_pkg::DATA_W-1:0]      back_q;

	logic                             accept;
	logic                             full;
	logic                             empty;
	logic                             greater;
	logic                             dump_walk;
	logic                             dump_last;
	logic [dwrs_pkg::IDX_W-1:0]       head_dec;
	logic [dwrs_pkg::IDX_W-1:0]       head_inc;
	logic [dwrs_pkg::IDX_W-1:0]       back_slot;
	logic [dwrs_pkg::CNT_W:0]         count_w;
	logic [dwrs_pkg::CNT_W:0]         sort_i_n;
	logic [dwrs_pkg::CNT_W:0]         sort_j_n;

	logic                             we;
	logic [dwrs_pkg::IDX_W-1:0]       waddr;
	logic [dwrs_pkg::DATA_W-1:0]      wdata;
	logic [dwrs_pkg::IDX_W-1:0]       raddr_a;
	logic [dwrs_pkg::IDX_W-1:0]       raddr_b;
	logic [dwrs_pkg::DATA_W-1:0]      rdata_a;
	logic [dwrs_pkg::DATA_W-1:0]      rdata_b;

	dwrs_ram #(
		.WIDTH(dwrs_pkg::DATA_W),
		.DEPTH(dwrs_pkg::DEPTH)
	) u_ram (
		.clk    (clk),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr_a(raddr_a),
		.raddr_b(raddr_b),
		.rdata_a(rdata_a),
		.rdata_b(rdata_b)
	);

	assign cmd_ready = (state_q == S_IDLE);
	assign accept    = cmd_valid && cmd_ready;
	assign full      = (count_q >= dwrs_pkg::CNT_W'(dwrs_pkg::DEPTH));
	assign empty     = (count_q == '0);
	assign count_w   = {1'b0, count_q};
	assign greater   = ($signed(rdata_a) > $signed(rdata_b));
	assign dump_walk = (op_q == dwrs_pkg::OP_DUMP) && !empty;
	assign dump_last = ((i_q + 1'b1) == count_w);

	assign head_dec = (head_q == '0) ? dwrs_pkg::IDX_W'(dwrs_pkg::DEPTH - 1) : head_q - 1'b1;
	assign head_inc = (head_q == dwrs_pkg::IDX_W'(dwrs_pkg::DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign back_slot = dwrs_pkg::slot(head_q, count_q[dwrs_pkg::IDX_W-1:0] - 1'b1);

	// Next pair of the exchange sort: advance j, or move i on and restart j.
	always_comb begin
		if ((j_q + 1'b1) < count_w) begin
			sort_i_n = i_q;
			sort_j_n = j_q + 1'b1;
		end else begin
			sort_i_n = i_q + 1'b1;
			sort_j_n = i_q + 2'd2;
		end
	end

	always_comb begin
		we    = 1'b0;
		waddr = dwrs_pkg::slot(head_q, i_q[dwrs_pkg::IDX_W-1:0]);
		wdata = rdata_b;
		case (state_q)
			S_IDLE: begin
				wdata = cmd.value;
				if (accept && !full) begin
					if (cmd.op == dwrs_pkg::OP_PUSH_FRONT) begin
						we    = 1'b1;
						waddr = head_dec;
					end else if (cmd.op == dwrs_pkg::OP_PUSH_BACK) begin
						we    = 1'b1;
						waddr = dwrs_pkg::slot(head_q, count_q[dwrs_pkg::IDX_W-1:0]);
					end
				end
			end
			S_XCHG: begin
				we = (op_q == dwrs_pkg::OP_REVERSE) || greater;
			end
			S_SWAP: begin
				we    = 1'b1;
				waddr = dwrs_pkg::slot(head_q, j_q[dwrs_pkg::IDX_W-1:0]);
				wdata = t_q;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		case (state_q)
			S_FETCH, S_SUM: begin
				raddr_a = head_q;
				raddr_b = back_slot;
			end
			default: begin
				raddr_a = dwrs_pkg::slot(head_q, i_q[dwrs_pkg::IDX_W-1:0]);
				raddr_b = dwrs_pkg::slot(head_q, j_q[dwrs_pkg::IDX_W-1:0]);
			end
		endcase
	end

	always_comb begin
		emit = ((state_q == S_SUM) && !dump_walk) || (state_q == S_DEMIT);
		res.count    = count_q;
		res.is_empty = empty;
		if (state_q == S_DEMIT) begin
			res.front_value = front_q;
			res.back_value  = back_q;
			res.status      = dwrs_pkg::ST_OK;
			res.elem_value  = rdata_a;
			res.elem_valid  = 1'b1;
			res.last        = dump_last;
		end else begin
			res.front_value = empty ? '1 : rdata_a;
			res.back_value  = empty ? '1 : rdata_b;
			res.status      = status_q;
			res.elem_value  = '0;
			res.elem_valid  = 1'b0;
			res.last        = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q <= cmd.op;
					i_q  <= '0;
					j_q  <= (cmd.op == dwrs_pkg::OP_REVERSE) ? count_w - 1'b1 : (dwrs_pkg::CNT_W+1)'(1);
				end
			end
			S_SUM: begin
				front_q <= rdata_a;
				back_q  <= rdata_b;
			end
			S_XCHG: begin
				t_q <= rdata_a;
				if (op_q == dwrs_pkg::OP_SORT && !greater) begin
					i_q <= sort_i_n;
					j_q <= sort_j_n;
				end
			end
			S_SWAP: begin
				if (op_q == dwrs_pkg::OP_REVERSE) begin
					i_q <= i_q + 1'b1;
					j_q <= j_q - 1'b1;
				end else begin
					i_q <= sort_i_n;
					j_q <= sort_j_n;
				end
			end
			S_DEMIT: begin
				if (take) begin
					i_q <= i_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			head_q   <= '0;
			count_q  <= '0;
			status_q <= dwrs_pkg::ST_OK;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						status_q <= dwrs_pkg::ST_OK;
						state_q  <= S_FETCH;
						case (cmd.op)
							dwrs_pkg::OP_PUSH_FRONT: begin
								if (full) begin
									status_q <= dwrs_pkg::ST_FULL;
								end else begin
									head_q  <= head_dec;
									count_q <= count_q + 1'b1;
								end
							end
							dwrs_pkg::OP_PUSH_BACK: begin
								if (full) begin
									status_q <= dwrs_pkg::ST_FULL;
								end else begin
									count_q <= count_q + 1'b1;
								end
							end
							dwrs_pkg::OP_POP_FRONT: begin
								if (empty) begin
									status_q <= dwrs_pkg::ST_EMPTY;
								end else begin
									head_q  <= head_inc;
									count_q <= count_q - 1'b1;
								end
							end
							dwrs_pkg::OP_POP_BACK: begin
								if (empty) begin
									status_q <= dwrs_pkg::ST_EMPTY;
								end else begin
									count_q <= count_q - 1'b1;
								end
							end
							dwrs_pkg::OP_REVERSE, dwrs_pkg::OP_SORT: begin
								if (count_q > dwrs_pkg::CNT_W'(1)) begin
									state_q <= S_READ;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_FETCH: begin
					state_q <= S_SUM;
				end
				S_SUM: begin
					if (dump_walk) begin
						state_q <= S_DREAD;
					end else if (take) begin
						state_q <= S_IDLE;
					end
				end
				S_READ: begin
					state_q <= S_XCHG;
				end
				S_XCHG: begin
					if (op_q == dwrs_pkg::OP_REVERSE || greater) begin
						state_q <= S_SWAP;
					end else if (sort_j_n >= count_w) begin
						state_q <= S_FETCH;
					end else begin
						state_q <= S_READ;
					end
				end
				S_SWAP: begin
					if (op_q == dwrs_pkg::OP_REVERSE) begin
						state_q <= ((i_q + 2'd2) < j_q) ? S_READ : S_FETCH;
					end else begin
						state_q <= (sort_j_n >= count_w) ? S_FETCH : S_READ;
					end
				end
				S_DREAD: begin
					state_q <= S_DEMIT;
				end
				S_DEMIT: begin
					if (take) begin
						state_q <= dump_last ? S_IDLE : S_DREAD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/dwrs_chk.sv -----
// Port level checker for the deque top level, with its bind statement.
module dwrs_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           cmd_valid,
	input logic           cmd_ready,
	input dwrs_pkg::cmd_t cmd,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input dwrs_pkg::rsp_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("Stalled response transaction changed.");

	a_busy_after_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("Command accepted while a previous transaction is in progress.");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.is_empty == (rsp.count == '0)))
		else $error("Empty flag disagrees with count.");

	a_empty_marks: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.is_empty |-> (rsp.front_value == '1) && (rsp.back_value == '1)
			&& !rsp.elem_valid)
		else $error("Empty deque reported an element.");

	a_elem_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.elem_valid |-> (rsp.elem_value == '0) && rsp.last)
		else $error("Summary transaction carries element data or is not last.");

endmodule

bind deque_with_reverse_and_sort dwrs_chk u_dwrs_chk (.*);
